@@ rtl/core/ieval_pkg.sv @@
// shared types, opcodes and sizes for the infix expression evaluator
`default_nettype none

package ieval_pkg;

  // arithmetic width of numbers, terms and totals
  localparam int VALUE_WIDTH = 32;
  // width of the result value port
  localparam int OUT_WIDTH   = 32;
  // divider step counter width
  localparam int DIV_CW      = $clog2(VALUE_WIDTH + 1);

  // token queue between front and back
  localparam int TQ_DEPTH = 2;
  localparam int TQ_AW    = (TQ_DEPTH > 1) ? $clog2(TQ_DEPTH) : 1;
  localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

  // operator codes
  typedef logic [1:0] op_t;
  localparam op_t OP_PLUS  = 2'd0;
  localparam op_t OP_MINUS = 2'd1;
  localparam op_t OP_MUL   = 2'd2;
  localparam op_t OP_DIV   = 2'd3;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one closed number handed from front to back
  typedef struct packed {
    op_t                     op;       // operator applied to number
    logic [VALUE_WIDTH-1:0]  number;   // number just read
    logic                    is_op;    // closing character was an operator
    op_t                     next_op;  // that operator, when is_op
    logic                    last;     // expression ends with this token
  } token_t;

endpackage

`default_nettype wire

@@ rtl/core/infix_integer_expression_evaluator_core.sv @@
// top level of the infix integer expression evaluator
//
//   channel  | direction | handshake          | word
//   ---------+-----------+--------------------+-------------------------------------
//   input    | in        | push / full        | char_code, end_of_expression
//   result   | out       | empty / pop        | value, divide_by_zero
//
// digits and spaces, like operators, are accepted only while the token
// queue is not full.
// an operator or end mark becomes a token; the back end applies + - and *
// itself and hands a nonzero / to the divider.
// an end mark makes the back end form the result in the output register.
// full rises while the two-entry token queue is full.
`default_nettype none

module infix_integer_expression_evaluator_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  output logic                              full,
  input  wire  [7:0]                        char_code,
  input  wire                               end_of_expression,
  output logic                              empty,
  input  wire                               pop,
  output logic [ieval_pkg::OUT_WIDTH-1:0]   value,
  output logic                              divide_by_zero
);
  import ieval_pkg::*;

  token_t fr_token;
  token_t tq_token;
  logic   fr_push;
  logic   tq_full;
  logic   tq_empty;
  logic   tq_pop;

  // character front end
  ieval_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .char_code         (char_code),
    .end_of_expression (end_of_expression),
    .tq_full           (tq_full),
    .tq_push           (fr_push),
    .tq_token          (fr_token)
  );

  // token queue
  ieval_tq u_tq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fr_push),
    .wr_token (fr_token),
    .q_full   (tq_full),
    .rd_en    (tq_pop),
    .rd_token (tq_token),
    .q_empty  (tq_empty)
  );

  // arithmetic back end
  ieval_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tq_empty       (tq_empty),
    .tq_token       (tq_token),
    .tq_pop         (tq_pop),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .divide_by_zero (divide_by_zero)
  );

endmodule

`default_nettype wire

@@ rtl/core/ieval_front.sv @@
// front end: reads characters, builds numbers and emits tokens
`default_nettype none

module ieval_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  output logic                  full,
  input  wire  [7:0]            char_code,
  input  wire                   end_of_expression,
  input  wire                   tq_full,
  output logic                  tq_push,
  output ieval_pkg::token_t     tq_token
);
  import ieval_pkg::*;

  logic [VALUE_WIDTH-1:0] number_accum;
  logic [VALUE_WIDTH-1:0] number_accum_next;
  op_t                    pending_op;
  op_t                    pending_op_next;

  logic                   accept;
  logic                   is_space;
  logic                   is_digit;
  logic                   is_oper;
  op_t                    char_op;
  logic [VALUE_WIDTH-1:0] digit_val;
  logic [VALUE_WIDTH-1:0] accum_x10;

  // word accepted whenever the token queue has room
  assign full   = tq_full;
  assign accept = push && !tq_full;

  // character classes
  assign is_space  = (char_code == CH_SPACE);
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_oper   = !is_space && !is_digit;
  assign digit_val = VALUE_WIDTH'(char_code - CH_ZERO);
  assign accum_x10 = (number_accum << 3) + (number_accum << 1);

  // operator code of the character, anything unknown divides
  always_comb begin
    priority if (char_code == CH_PLUS) begin
      char_op = OP_PLUS;
    end else if (char_code == CH_MINUS) begin
      char_op = OP_MINUS;
    end else if (char_code == CH_STAR) begin
      char_op = OP_MUL;
    end else begin
      char_op = OP_DIV;
    end
  end

  // number build-up and token forming
  always_comb begin
    number_accum_next = number_accum;
    pending_op_next   = pending_op;
    tq_push           = 1'b0;
    tq_token.op       = pending_op;
    tq_token.number   = number_accum;
    tq_token.is_op    = is_oper;
    tq_token.next_op  = char_op;
    tq_token.last     = end_of_expression;
    if (accept) begin
      if (is_digit) begin
        number_accum_next = accum_x10 + digit_val;
        tq_token.number   = number_accum_next;
      end
      if (is_oper) begin
        number_accum_next = '0;
        pending_op_next   = char_op;
      end
      tq_push = is_oper || end_of_expression;
      if (end_of_expression) begin
        number_accum_next = '0;
        pending_op_next   = OP_PLUS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_accum <= '0;
      pending_op   <= OP_PLUS;
    end else begin
      number_accum <= number_accum_next;
      pending_op   <= pending_op_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ieval_tq.sv @@
// small token queue between front and back
`default_nettype none

module ieval_tq (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr_en,
  input  ieval_pkg::token_t  wr_token,
  output logic               q_full,
  input  wire                rd_en,
  output ieval_pkg::token_t  rd_token,
  output logic               q_empty
);
  import ieval_pkg::*;

  token_t           slots [TQ_DEPTH];
  logic [TQ_AW-1:0] wr_ptr;
  logic [TQ_AW-1:0] rd_ptr;
  logic [TQ_CW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = (count == TQ_CW'(TQ_DEPTH));
  assign q_empty  = (count == '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && !q_empty;
  assign rd_token = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_token;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == TQ_AW'(TQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == TQ_AW'(TQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ieval_div.sv @@
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module ieval_div (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire  [ieval_pkg::VALUE_WIDTH-1:0]  dividend,
  input  wire  [ieval_pkg::VALUE_WIDTH-1:0]  divisor,
  output logic                               done,
  output logic [ieval_pkg::VALUE_WIDTH-1:0]  quotient
);
  import ieval_pkg::*;

  logic                   running;
  logic [DIV_CW-1:0]      cnt;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] dmag;
  logic                   q_neg;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   a_neg;
  logic                   b_neg;

  assign a_neg   = dividend[VALUE_WIDTH-1];
  assign b_neg   = divisor[VALUE_WIDTH-1];
  assign shifted = {rem, quo[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dmag};

  // sign fix of the finished magnitude quotient
  assign quotient = q_neg ? (VALUE_WIDTH'(0) - quo) : quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_CW'(VALUE_WIDTH);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // restoring shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= a_neg ? (VALUE_WIDTH'(0) - dividend) : dividend;
      dmag  <= b_neg ? (VALUE_WIDTH'(0) - divisor) : divisor;
      q_neg <= a_neg ^ b_neg;
    end else if (running) begin
      if (!diff[VALUE_WIDTH]) begin
        rem <= diff[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ieval_back.sv @@
// back end: applies tokens to the running total and last term, emits results
`default_nettype none

module ieval_back (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  tq_empty,
  input  ieval_pkg::token_t                    tq_token,
  output logic                                 tq_pop,
  output logic                                 empty,
  input  wire                                  pop,
  output logic [ieval_pkg::OUT_WIDTH-1:0]      value,
  output logic                                 divide_by_zero
);
  import ieval_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]             state;
  token_t                 tok;
  logic [VALUE_WIDTH-1:0] running_total;
  logic [VALUE_WIDTH-1:0] last_term;
  logic                   error_seen;
  logic                   out_valid;

  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic                   n_zero;
  logic                   out_free;
  logic                   flush_adds;
  logic [VALUE_WIDTH-1:0] fin_val;
  logic signed [63:0]     fin_ext;

  ieval_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (last_term),
    .divisor  (tok.number),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign n_zero    = (tok.number == '0);
  assign tq_pop    = (state == S_IDLE) && !tq_empty;
  assign div_start = (state == S_EXEC) && (tok.op == OP_DIV) && !n_zero;
  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;

  // final flush: a trailing + or -, or no trailing operator, closes the open term; * and / zero it
  assign flush_adds = !tok.is_op || (tok.next_op == OP_PLUS) || (tok.next_op == OP_MINUS);
  assign fin_val    = flush_adds ? (running_total + last_term) : running_total;
  assign fin_ext    = 64'(signed'(fin_val));

  // sequencer and term arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_total <= '0;
      last_term     <= '0;
      error_seen    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!tq_empty) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= tok.last ? S_FIN : S_IDLE;
          unique case (tok.op)
            OP_PLUS: begin
              running_total <= running_total + last_term;
              last_term     <= tok.number;
            end
            OP_MINUS: begin
              running_total <= running_total + last_term;
              last_term     <= VALUE_WIDTH'(0) - tok.number;
            end
            OP_MUL: begin
              last_term <= VALUE_WIDTH'(last_term * tok.number);
            end
            OP_DIV: begin
              if (n_zero) begin
                error_seen <= 1'b1;
                last_term  <= '0;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            last_term <= div_quo;
            state     <= tok.last ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            running_total <= '0;
            last_term     <= '0;
            error_seen    <= 1'b0;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  // token capture
  always_ff @(posedge clk) begin
    if (tq_pop) begin
      tok <= tq_token;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      value          <= fin_ext[OUT_WIDTH-1:0];
      divide_by_zero <= error_seen || (tok.is_op && (tok.next_op == OP_DIV));
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ieval_checker.sv @@
// port-level checks for the expression evaluator, bound to the top level
`default_nettype none

module ieval_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               full,
  input wire                               empty,
  input wire                               pop,
  input wire [ieval_pkg::OUT_WIDTH-1:0]    value,
  input wire                               divide_by_zero
);

  // reset leaves no result waiting
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // reset leaves the input side open
  a_rst_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(divide_by_zero)))
    else $error("waiting result changed");

  // a waiting result carries known bits
  a_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({value, divide_by_zero}))
    else $error("waiting result has unknown bits");

endmodule

bind infix_integer_expression_evaluator_core ieval_checker u_ieval_checker (.*);

`default_nettype wire

@@ tb/tb_infix_integer_expression_evaluator_core.sv @@
// testbench for the infix integer expression evaluator core
`default_nettype none

module tb_infix_integer_expression_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ieval_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    logic                 dz;
  } total_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           char_code;
  logic                 end_of_expression;
  logic                 empty;
  logic                 pop;
  logic [OUT_WIDTH-1:0] value;
  logic                 divide_by_zero;

  infix_integer_expression_evaluator_core dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .char_code         (char_code),
    .end_of_expression (end_of_expression),
    .empty             (empty),
    .pop               (pop),
    .value             (value),
    .divide_by_zero    (divide_by_zero)
  );

  // evaluator state as predicted
  logic [VW-1:0] num_acc;
  op_t           pend_op;
  logic [VW-1:0] open_term;
  logic [VW-1:0] closed_sum;
  logic          dz_seen;

  total_t totals_due[$];
  int     errors;
  int     chars_sent;
  int     totals_checked;
  int     dz_totals;
  bit     steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    if (errors < 40) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VW-1:0] div_trunc(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW-1:0] ma;
    logic [VW-1:0] mb;
    logic [VW-1:0] q;
    ma = a[VW-1] ? -a : a;
    mb = b[VW-1] ? -b : b;
    q  = ma / mb;
    if (a[VW-1] != b[VW-1]) q = -q;
    return q;
  endfunction

  task automatic clear_state();
    num_acc    = '0;
    pend_op    = OP_PLUS;
    open_term  = '0;
    closed_sum = '0;
    dz_seen    = 1'b0;
  endtask

  // apply the finished number to the open term
  task automatic fold_operand();
    case (pend_op)
      OP_PLUS: begin
        closed_sum = closed_sum + open_term;
        open_term  = num_acc;
      end
      OP_MINUS: begin
        closed_sum = closed_sum + open_term;
        open_term  = -num_acc;
      end
      OP_MUL: begin
        open_term = open_term * num_acc;
      end
      default: begin
        if (num_acc == '0) begin
          dz_seen   = 1'b1;
          open_term = '0;
        end else begin
          open_term = div_trunc(open_term, num_acc);
        end
      end
    endcase
    num_acc = '0;
  endtask

  // predict the effect of one accepted word
  task automatic evaluate_char(input logic [7:0] ch, input logic last);
    logic [VW-1:0] sum;
    longint        wide;
    total_t        t;
    if (ch == CH_SPACE) begin
      // spaces are skipped
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      num_acc = num_acc * 10 + VW'(ch - CH_ZERO);
    end else begin
      fold_operand();
      if (ch == CH_PLUS) pend_op = OP_PLUS;
      else if (ch == CH_MINUS) pend_op = OP_MINUS;
      else if (ch == CH_STAR) pend_op = OP_MUL;
      else pend_op = OP_DIV;
    end
    if (last) begin
      fold_operand();
      sum     = closed_sum + open_term;
      wide    = $signed(sum);
      t.value = wide[OUT_WIDTH-1:0];
      t.dz    = dz_seen;
      totals_due.push_back(t);
      clear_state();
    end
  endtask

  // send one word and wait until it is taken
  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push              = 1'b0;
      char_code         = 8'($urandom);
      end_of_expression = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    push              = 1'b1;
    char_code         = ch;
    end_of_expression = last;
    do @(posedge clk); while (full);
    evaluate_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_expr(input logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] pick_other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_PLUS ||
           c == CH_MINUS || c == CH_STAR);
    return c;
  endfunction

  task automatic add_number(ref logic [7:0] text[$], input int ndig);
    for (int k = 0; k < ndig; k++) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // directed: extremes and the corner cases
  task automatic run_directed();
    logic [7:0] text[$];
    // most negative value divided by minus one, via a wrapped number
    text = '{CH_MINUS, "2", "1", "4", "7", "4", "8", "3", "6", "4", "8", CH_SLASH,
             "4", "2", "9", "4", "9", "6", "7", "2", "9", "5"};
    send_expr(text);
    // odd character as division by zero, trailing plus, space as last word
    text = '{"6", CH_STAR, "2", 8'hFF, "0", CH_PLUS, CH_SPACE};
    send_expr(text);
    // leading multiply with no number before it, then end on a zero byte
    text = '{CH_STAR, "5", 8'h00};
    send_expr(text);
  endtask

  // mostly well-formed expressions with random content
  task automatic run_expressions(input int budget);
    logic [7:0] text[$];
    int         nterms;
    int         r;
    int         stop_at;
    bit         is_div;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      text.delete();
      nterms = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) text.push_back(CH_MINUS);
      for (int t = 0; t < nterms; t++) begin
        is_div = 1'b0;
        if (t > 0) begin
          if ($urandom_range(0, 4) == 0) text.push_back(CH_SPACE);
          r = $urandom_range(0, 99);
          if (r < 30) text.push_back(CH_PLUS);
          else if (r < 55) text.push_back(CH_MINUS);
          else if (r < 80) text.push_back(CH_STAR);
          else begin
            text.push_back(r < 95 ? CH_SLASH : pick_other_char());
            is_div = 1'b1;
          end
          if ($urandom_range(0, 4) == 0) text.push_back(CH_SPACE);
        end
        r = $urandom_range(0, 99);
        if (is_div && r < 15) text.push_back(CH_ZERO);
        else if (r < 8) begin
          // operand left out
        end else if (r < 75) add_number(text, $urandom_range(1, 3));
        else if (r < 92) add_number(text, $urandom_range(4, 7));
        else add_number(text, $urandom_range(8, 11));
      end
      if (text.size() == 0 || $urandom_range(0, 9) == 0) text.push_back(CH_SPACE);
      send_expr(text);
    end
  endtask

  // random bytes with random end marks
  task automatic run_noise(input int budget);
    for (int i = 0; i < budget; i++)
      send_char(8'($urandom_range(0, 255)), i == budget - 1 || $urandom_range(0, 9) == 0);
  endtask

  // result side: random pop stalls
  initial begin
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop = 1'b0;
      end else if (steady || hold == 0) begin
        pop = 1'b1;
        if (!steady) hold = pick_gap();
      end else begin
        pop = 1'b0;
        hold--;
      end
    end
  end

  // compare each popped word with the oldest predicted total
  initial begin
    total_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (totals_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value=%0d dz=%0b",
                                  $signed(value), divide_by_zero));
        end else begin
          want = totals_due.pop_front();
          totals_checked++;
          if (want.dz) dz_totals++;
          if (value !== want.value)
            flag_mismatch($sformatf("value %0d, expected %0d",
                                    $signed(value), $signed(want.value)));
          if (divide_by_zero !== want.dz)
            flag_mismatch($sformatf("divide_by_zero %0b, expected %0b",
                                    divide_by_zero, want.dz));
        end
      end
    end
  end

  // test sequence
  initial begin
    int waited;
    rst               = 1'b1;
    push              = 1'b0;
    char_code         = '0;
    end_of_expression = 1'b0;
    errors            = 0;
    chars_sent        = 0;
    totals_checked    = 0;
    dz_totals         = 0;
    steady            = 1'b0;
    clear_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    steady = 1'b1;
    run_expressions(300);
    steady = 1'b0;
    run_expressions(900);
    run_noise(320);
    @(negedge clk);
    push = 1'b0;

    // drain outstanding results
    waited = 0;
    while (totals_due.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (totals_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", totals_due.size()));
    repeat (60) @(posedge clk);

    $display("covered %0d characters, %0d expression totals checked (%0d with divide by zero)",
             chars_sent, totals_checked, dz_totals);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/ieval_pkg.sv
rtl/core/ieval_front.sv
rtl/core/ieval_tq.sv
rtl/core/ieval_div.sv
rtl/core/ieval_back.sv
rtl/core/infix_integer_expression_evaluator_core.sv
rtl/core/ieval_checker.sv
tb/tb_infix_integer_expression_evaluator_core.sv
